// ===== src/bounded_doubly_linked_list_macros.svh =====
// Assertion macros for the bounded doubly linked list.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_MACROS_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_MACROS_SVH

// Assert that a property holds on every clock edge outside reset.
`define BDLL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a signal is low while the block is in reset.
`define BDLL_ASSERT_RST(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) !rst_n |-> !(sig)) else $error(msg);

`endif

// ===== src/bdll_pkg.sv =====
// Package: types and constants of the bounded doubly linked list.
`default_nettype none
package bdll_pkg;
  localparam int Capacity  = 16;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int ValueBits = 32;

  localparam logic [2:0] CmdAppend    = 3'd0;
  localparam logic [2:0] CmdInsertAt  = 3'd1;
  localparam logic [2:0] CmdRemHead   = 3'd2;
  localparam logic [2:0] CmdRemTail   = 3'd3;
  localparam logic [2:0] CmdRemAt     = 3'd4;
  localparam logic [2:0] CmdRemValue  = 3'd5;
  localparam logic [2:0] CmdDumpFwd   = 3'd6;
  localparam logic [2:0] CmdDumpRev   = 3'd7;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StBadPos   = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] item_value;
    logic [4:0]         position;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_value;
    logic [4:0]         element_count;
    logic               last;
  } rsp_t;
endpackage
`default_nettype wire

// ===== src/bounded_doubly_linked_list.sv =====
// Top level: bounded doubly linked list with a link-walking sequencer.
// Append, remove head/tail and insert at either end: SWalk, then SExec registers the strobe;
// insert at / remove at position k walks k links first (k <= 15, none on a bad position).
// Remove value: SWalk and SDone per compared entry, then SExec (no compare when empty).
// Dump of n elements: one result per element, a single result when empty; no stalls.
// Reset clears head, tail, count and rebuilds the free chain at once.
`default_nettype none
`include "bounded_doubly_linked_list_macros.svh"
module bounded_doubly_linked_list
  import bdll_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire cmd_t cmd_i,
  output logic      busy_o,
  output logic      strobe_o,
  output rsp_t      rsp_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SWalk = 3'd1;
  localparam logic [2:0] SExec = 3'd2;
  localparam logic [2:0] SDump = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  logic [ValueBits-1:0] val_mem [Capacity];
  logic [IdxW-1:0]      nxt_q [Capacity];
  logic [IdxW-1:0]      prv_q [Capacity];
  logic [IdxW-1:0]      head_q, tail_q, free_q, cur_q;
  logic [CntW-1:0]      cnt_q, step_q;
  logic [2:0]           state_q;
  cmd_t                 cmd_q;
  logic [ValueBits-1:0] rd_q;
  logic                 match_q;

  // Read port: value of the current entry, registered
  always_ff @(posedge clk_i) begin
    rd_q <= val_mem[cur_q];
  end

  logic [CntW-1:0] cnt_dec;
  assign cnt_dec = cnt_q - CntW'(1);

  // Main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [IdxW-1:0] e, p, n, idx;
    if (!rst_ni) begin
      state_q  <= SIdle;
      head_q   <= '0;
      tail_q   <= '0;
      free_q   <= '0;
      cnt_q    <= '0;
      cur_q    <= '0;
      step_q   <= '0;
      match_q  <= 1'b0;
      cmd_q    <= '0;
      rsp_o    <= '0;
      strobe_o <= 1'b0;
      for (int i = 0; i < Capacity; i++) begin
        nxt_q[i] <= IdxW'((i + 1) % Capacity);
      end
    end else begin
      strobe_o <= 1'b0;
      case (state_q)
        SIdle: begin
          if (start_i) begin
            cmd_q   <= cmd_i;
            step_q  <= '0;
            match_q <= 1'b0;
            cur_q   <= (cmd_i.command == CmdRemTail || cmd_i.command == CmdDumpRev)
                       ? tail_q : head_q;
            state_q <= SWalk;
          end
        end
        // Walk: one link a cycle toward position, or on to the value compare or the dump
        SWalk: begin
          if (cmd_q.command == CmdDumpFwd || cmd_q.command == CmdDumpRev) begin
            state_q <= (cnt_q == '0) ? SExec : SDump;
          end else if (cmd_q.command == CmdRemValue) begin
            if (cnt_q != '0 && step_q < cnt_q) begin
              state_q <= SDone;
              match_q <= 1'b0;
            end else begin
              state_q <= SExec;
            end
          end else if ((cmd_q.command == CmdInsertAt || cmd_q.command == CmdRemAt)
                       && CntW'(step_q) < cmd_q.position[CntW-1:0]
                       && cmd_q.position < 5'(cnt_q)) begin
            cur_q  <= nxt_q[cur_q];
            step_q <= step_q + CntW'(1);
          end else begin
            state_q <= SExec;
          end
        end
        // Value compare: rd_q now holds the current entry value
        SDone: begin
          if (rd_q == cmd_q.item_value) begin
            match_q <= 1'b1;
            state_q <= SExec;
          end else if (step_q + CntW'(1) >= cnt_q) begin
            state_q <= SExec;
          end else begin
            cur_q   <= nxt_q[cur_q];
            step_q  <= step_q + CntW'(1);
            state_q <= SWalk;
          end
        end
        // Dump: one element per visit, then back to SWalk for the next link
        SDump: begin
          strobe_o            <= 1'b1;
          rsp_o.status        <= StOk;
          rsp_o.out_value     <= rd_q;
          rsp_o.element_count <= 5'(cnt_q);
          rsp_o.last          <= (step_q + CntW'(1) == cnt_q);
          if (step_q + CntW'(1) == cnt_q) begin
            state_q <= SIdle;
          end else begin
            step_q  <= step_q + CntW'(1);
            cur_q   <= (cmd_q.command == CmdDumpFwd) ? nxt_q[cur_q] : prv_q[cur_q];
            state_q <= SWalk;
          end
        end
        // Execute: link update and the single result
        SExec: begin
          strobe_o            <= 1'b1;
          rsp_o.last          <= 1'b1;
          rsp_o.out_value     <= '0;
          rsp_o.status        <= StOk;
          rsp_o.element_count <= 5'(cnt_q);
          state_q             <= SIdle;
          case (cmd_q.command)
            CmdAppend, CmdInsertAt: begin
              if (cnt_q >= CntW'(Capacity)) begin
                rsp_o.status <= StFull;
              end else if (cmd_q.command == CmdInsertAt && cmd_q.position > 5'(cnt_q)) begin
                rsp_o.status <= StBadPos;
              end else begin
                e = free_q;
                free_q <= nxt_q[e];
                val_mem[e] <= cmd_q.item_value;
                rsp_o.element_count <= 5'(cnt_q + CntW'(1));
                cnt_q <= cnt_q + CntW'(1);
                if (cnt_q == '0) begin
                  head_q <= e;
                  tail_q <= e;
                end else if (cmd_q.command == CmdAppend || cmd_q.position >= 5'(cnt_q)) begin
                  prv_q[e]      <= tail_q;
                  nxt_q[tail_q] <= e;
                  tail_q        <= e;
                end else if (cmd_q.position == '0) begin
                  nxt_q[e]      <= head_q;
                  prv_q[head_q] <= e;
                  head_q        <= e;
                end else begin
                  p = prv_q[cur_q];
                  nxt_q[e]     <= cur_q;
                  prv_q[e]     <= p;
                  nxt_q[p]     <= e;
                  prv_q[cur_q] <= e;
                end
              end
            end
            CmdRemHead, CmdRemTail, CmdRemAt, CmdRemValue: begin
              if (cnt_q == '0) begin
                rsp_o.status <= StEmpty;
              end else if (cmd_q.command == CmdRemAt && cmd_q.position >= 5'(cnt_q)) begin
                rsp_o.status <= StBadPos;
              end else if (cmd_q.command == CmdRemValue && !match_q) begin
                rsp_o.status <= StNotFound;
              end else begin
                idx = cur_q;
                p = prv_q[idx];
                n = nxt_q[idx];
                rsp_o.out_value     <= rd_q;
                rsp_o.element_count <= 5'(cnt_dec);
                cnt_q <= cnt_dec;
                if (idx == head_q) head_q <= n;
                else nxt_q[p] <= n;
                if (idx == tail_q) tail_q <= p;
                else prv_q[n] <= p;
                if (cnt_dec == '0) begin
                  head_q <= '0;
                  tail_q <= '0;
                end
                nxt_q[idx] <= free_q;
                free_q     <= idx;
              end
            end
            default: begin
              rsp_o.status <= StEmpty;
            end
          endcase
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy_o = (state_q != SIdle);

  `BDLL_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(Capacity), "count over capacity")
  `BDLL_ASSERT(a_strobe_idle, clk_i, rst_ni, strobe_o && rsp_o.last |-> !busy_o, "last while busy")
  `BDLL_ASSERT(a_empty_ends, clk_i, rst_ni, cnt_q == '0 |-> (head_q | tail_q) == '0, "stale ends")
  `BDLL_ASSERT_RST(a_rst_strobe, clk_i, rst_ni, strobe_o, "strobe during reset")
endmodule
`default_nettype wire

// ===== verif/tb_bounded_doubly_linked_list.sv =====
// Testbench: random and directed command traffic against a behavioral list model.
`timescale 1ns / 1ps
module tb_bounded_doubly_linked_list;
  import bdll_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i = '0;
  logic busy_o;
  logic strobe_o;
  rsp_t rsp_o;

  bounded_doubly_linked_list dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .cmd_i(cmd_i),
    .busy_o(busy_o), .strobe_o(strobe_o), .rsp_o(rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model list kept as an ordered queue of values
  logic signed [31:0] model_list[$];
  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];
  int   gap_list[$];
  int   error_count = 0;
  int   cycle_count = 0;
  bit   stim_done = 1'b0;
  bit   drain_hold = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic rsp_t make_rsp(logic [2:0] st, logic signed [31:0] v, logic lst);
    rsp_t r;
    r.status = st;
    r.out_value = v;
    r.element_count = 5'(model_list.size());
    r.last = lst;
    return r;
  endfunction

  // Apply one command to the model and queue the results it causes
  task automatic predict_list_op(input cmd_t c);
    int n;
    int hit;
    logic signed [31:0] v;
    n = model_list.size();
    hit = -1;
    v = '0;
    case (c.command)
      CmdAppend, CmdInsertAt: begin
        if (n >= Capacity) expected_rsps.push_back(make_rsp(StFull, 0, 1'b1));
        else if (c.command == CmdInsertAt && int'(c.position) > n)
          expected_rsps.push_back(make_rsp(StBadPos, 0, 1'b1));
        else begin
          if (c.command == CmdAppend) model_list.push_back(c.item_value);
          else model_list.insert(int'(c.position), c.item_value);
          expected_rsps.push_back(make_rsp(StOk, 0, 1'b1));
        end
      end
      CmdRemHead, CmdRemTail, CmdRemAt, CmdRemValue: begin
        if (n == 0) expected_rsps.push_back(make_rsp(StEmpty, 0, 1'b1));
        else begin
          if (c.command == CmdRemHead) hit = 0;
          else if (c.command == CmdRemTail) hit = n - 1;
          else if (c.command == CmdRemAt) hit = (int'(c.position) < n) ? int'(c.position) : -2;
          else begin
            for (int i = 0; i < n; i++)
              if (hit == -1 && model_list[i] == c.item_value) hit = i;
            if (hit == -1) hit = -3;
          end
          if (hit == -2) expected_rsps.push_back(make_rsp(StBadPos, 0, 1'b1));
          else if (hit == -3) expected_rsps.push_back(make_rsp(StNotFound, 0, 1'b1));
          else begin
            v = model_list[hit];
            model_list.delete(hit);
            expected_rsps.push_back(make_rsp(StOk, v, 1'b1));
          end
        end
      end
      default: begin
        if (n == 0) expected_rsps.push_back(make_rsp(StEmpty, 0, 1'b1));
        else for (int i = 0; i < n; i++)
          expected_rsps.push_back(make_rsp(StOk,
              model_list[c.command == CmdDumpFwd ? i : n - 1 - i], i == n - 1));
      end
    endcase
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic add_cmd(input logic [2:0] op, input logic signed [31:0] v, input int p);
    cmd_t c;
    c.command = op;
    c.item_value = v;
    c.position = 5'(p);
    pending_cmds.push_back(c);
    gap_list.push_back(pick_gap());
  endtask

  // Stimulus: directed corner cases, then random traffic biased by fill level
  initial begin
    int fill;
    logic signed [31:0] recent[$];
    logic [2:0] op;
    logic signed [31:0] v;
    add_cmd(CmdRemHead, 0, 0);
    add_cmd(CmdRemTail, 0, 0);
    add_cmd(CmdRemAt, 0, 0);
    add_cmd(CmdRemValue, 5, 0);
    add_cmd(CmdDumpFwd, 0, 0);
    add_cmd(CmdDumpRev, 0, 0);
    add_cmd(CmdInsertAt, 32'sh7fffffff, 1);
    add_cmd(CmdInsertAt, 32'sh7fffffff, 0);
    add_cmd(CmdInsertAt, 32'sh80000000, 0);
    add_cmd(CmdInsertAt, -1, 2);
    add_cmd(CmdAppend, 0, 31);
    add_cmd(CmdRemValue, 32'sh7fffffff, 0);
    add_cmd(CmdRemValue, 32'sh80000000, 0);
    add_cmd(CmdRemValue, 12345, 0);
    add_cmd(CmdRemAt, 0, 16);
    add_cmd(CmdRemAt, 0, 1);
    for (int i = 0; i < 17; i++) add_cmd(CmdAppend, i * 3 - 7, 0);
    add_cmd(CmdInsertAt, 1, 0);
    add_cmd(CmdDumpFwd, 0, 0);
    add_cmd(CmdDumpRev, 0, 0);
    add_cmd(CmdRemAt, 0, 15);
    add_cmd(CmdRemTail, 0, 0);
    fill = 14;
    for (int k = 0; k < 212; k++) begin
      op = 3'($urandom_range(0, 7));
      if (fill < 4 && op inside {CmdRemHead, CmdRemTail, CmdRemAt, CmdRemValue}
          && $urandom_range(0, 1)) op = CmdAppend;
      v = (recent.size() > 0 && $urandom_range(0, 2) != 0)
          ? recent[$urandom_range(0, recent.size() - 1)] : $signed($urandom());
      if (op == CmdRemValue && $urandom_range(0, 4) == 0) v = $signed($urandom());
      add_cmd(op, v, $urandom_range(0, 1) ? $urandom_range(0, fill + 1) : $urandom_range(0, 31));
      if (op inside {CmdAppend, CmdInsertAt}) begin
        recent.push_back(v);
        if (fill < 16) fill++;
      end else if (op inside {CmdRemHead, CmdRemTail, CmdRemAt, CmdRemValue} && fill > 0) fill--;
      if (recent.size() > 20) void'(recent.pop_front());
    end
  end

  // Driver: one command per transfer, with random gaps and a drain hold-off
  int gap_left = 0;
  int sent_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_list_op(cmd_i);
        sent_count <= sent_count + 1;
        if (sent_count == 120) drain_hold <= 1'b1;
        if (pending_cmds.size() > 0 && gap_list[0] == 0 && sent_count != 120) begin
          cmd_i <= pending_cmds.pop_front();
          void'(gap_list.pop_front());
        end else begin
          start_i <= 1'b0;
          if (pending_cmds.size() == 0) stim_done <= 1'b1;
          else gap_left <= gap_list.pop_front();
        end
      end else if (!start_i) begin
        if (drain_hold) begin
          if (expected_rsps.size() == 0) drain_hold <= 1'b0;
        end else if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_cmds.size() > 0) begin
          cmd_i <= pending_cmds.pop_front();
          start_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && strobe_o) begin
      if (expected_rsps.size() == 0)
        report_mismatch("unexpected result", int'(rsp_o.out_value), 0);
      else begin
        want = expected_rsps.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch("status", int'(rsp_o.status), int'(want.status));
        if (rsp_o.out_value !== want.out_value)
          report_mismatch("out_value", int'(rsp_o.out_value), int'(want.out_value));
        if (rsp_o.element_count !== want.element_count)
          report_mismatch("element_count", int'(rsp_o.element_count),
                          int'(want.element_count));
        if (rsp_o.last !== want.last)
          report_mismatch("last", int'(rsp_o.last), int'(want.last));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (stim_done && expected_rsps.size() == 0);
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
